// File: sv/fpp_pkg.sv
// Shared definitions for the framed packet parser: frame constants, the CRC-16
// byte update, the reply byte table and the parser-to-transmitter request type.
// No dependencies.
package fpp_pkg;

    localparam logic [7:0]  HDR1_BYTE     = 8'h48;
    localparam logic [7:0]  HDR2_BYTE     = 8'h5A;
    localparam logic [7:0]  TAIL1_BYTE    = 8'hEE;
    localparam logic [7:0]  TAIL2_BYTE    = 8'hFF;
    localparam logic [7:0]  CMD_READ      = 8'h03;
    localparam logic [7:0]  CMD_CTRL      = 8'hC0;
    localparam logic [7:0]  ZERO_BYTE     = 8'h00;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'hA001;

    localparam logic [7:0]  ADDR_RESET    = 8'h02;
    localparam logic [7:0]  MAXLEN_RESET  = 8'd100;
    localparam logic [15:0] BYPASS_RESET  = 16'hAAAA;

    // Offset of the first data byte within the frame (header, address, length,
    // reserved byte come first).
    localparam logic [8:0]  DATA_START    = 9'd5;

    // Index of the final reply byte for each command.
    localparam logic [3:0]  LAST_IDX_READ = 4'd10;
    localparam logic [3:0]  LAST_IDX_CTRL = 4'd11;

    typedef struct packed {
        logic valid;
        logic is_ctrl;
    } reply_req_t;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    // Reply payloads are fixed, so their CRCs are worked out at elaboration.
    localparam logic [15:0] CRC_REPLY_READ =
        crc_feed(crc_feed(CRC_INIT, CMD_READ), ZERO_BYTE);
    localparam logic [15:0] CRC_REPLY_CTRL =
        crc_feed(crc_feed(crc_feed(CRC_INIT, CMD_CTRL), ZERO_BYTE), ZERO_BYTE);

    function automatic logic [7:0] reply_byte(input logic is_ctrl, input logic [3:0] idx,
                                              input logic [7:0] addr);
        logic [7:0] r;
        r = ZERO_BYTE;
        if (is_ctrl) begin
            case (idx)
                4'd0:    r = HDR1_BYTE;
                4'd1:    r = HDR2_BYTE;
                4'd2:    r = addr;
                4'd3:    r = 8'h03;
                4'd5:    r = CMD_CTRL;
                4'd8:    r = CRC_REPLY_CTRL[15:8];
                4'd9:    r = CRC_REPLY_CTRL[7:0];
                4'd10:   r = TAIL1_BYTE;
                4'd11:   r = TAIL2_BYTE;
                default: r = ZERO_BYTE;
            endcase
        end else begin
            case (idx)
                4'd0:    r = HDR1_BYTE;
                4'd1:    r = HDR2_BYTE;
                4'd2:    r = addr;
                4'd3:    r = 8'h02;
                4'd5:    r = CMD_READ;
                4'd7:    r = CRC_REPLY_READ[15:8];
                4'd8:    r = CRC_REPLY_READ[7:0];
                4'd9:    r = TAIL1_BYTE;
                4'd10:   r = TAIL2_BYTE;
                default: r = ZERO_BYTE;
            endcase
        end
        return r;
    endfunction

endpackage

// File: sv/fpp_parser.sv
// Frame parser: walks the receive frame one byte per cycle while no reply waits on
// tx_busy, checks the CRC and tail, and raises a reply request. Depends on fpp_pkg.
module fpp_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  logic [7:0]         rx_byte,
    input  logic               timed_out,
    input  logic [7:0]         device_address,
    input  logic [7:0]         max_length,
    input  logic [15:0]        crc_bypass_code,
    input  logic               tx_busy,
    output logic               take,
    output fpp_pkg::reply_req_t req
);
    import fpp_pkg::*;

    typedef enum logic [9:0] {
        PH_IDLE  = 10'b0000000001,
        PH_HDR2  = 10'b0000000010,
        PH_ADDR  = 10'b0000000100,
        PH_LEN   = 10'b0000001000,
        PH_RES   = 10'b0000010000,
        PH_DATA  = 10'b0000100000,
        PH_CRCH  = 10'b0001000000,
        PH_CRCL  = 10'b0010000000,
        PH_TAIL1 = 10'b0100000000,
        PH_TAIL2 = 10'b1000000000
    } phase_t;

    phase_t      phase_reg, phase_next, phase_eff;
    logic [8:0]  byte_index_reg, byte_index_next, idx, frame_end;
    logic [7:0]  frame_length_reg, frame_length_next;
    logic [15:0] running_crc_reg, running_crc_next;
    logic [15:0] computed_crc_reg, computed_crc_next;
    logic [7:0]  crc_high_reg, crc_high_next;
    logic [7:0]  command_reg, command_next;
    logic [15:0] crc_seed, crc_upd, crc_rcvd;
    logic        cmd_known, fire_cond;

    always_comb
    begin
        phase_eff = timed_out ? PH_IDLE : phase_reg;
        idx       = (phase_eff == PH_IDLE) ? 9'd0 : byte_index_reg;
        frame_end = {1'b0, frame_length_reg} + DATA_START;
        crc_seed  = (phase_eff == PH_ADDR) ? CRC_INIT : running_crc_reg;
        crc_upd   = crc_feed(crc_seed, rx_byte);
        crc_rcvd  = {crc_high_reg, rx_byte};
        cmd_known = (command_reg == CMD_READ) || (command_reg == CMD_CTRL);
        fire_cond = (phase_eff == PH_TAIL2) && (rx_byte == TAIL2_BYTE) && cmd_known;
        // A byte that would start a second reply waits while the transmitter is busy.
        take      = item_valid && !(fire_cond && tx_busy);
        req.valid   = take && fire_cond;
        req.is_ctrl = (command_reg == CMD_CTRL);

        phase_next        = phase_reg;
        byte_index_next   = byte_index_reg;
        frame_length_next = frame_length_reg;
        running_crc_next  = running_crc_reg;
        computed_crc_next = computed_crc_reg;
        crc_high_next     = crc_high_reg;
        command_next      = command_reg;

        if (take) begin
            byte_index_next = idx + 9'd1;
            case (phase_eff)
                PH_IDLE:
                begin
                    phase_next = (rx_byte == HDR1_BYTE) ? PH_HDR2 : PH_IDLE;
                end
                PH_HDR2:
                begin
                    phase_next = (rx_byte == HDR2_BYTE) ? PH_ADDR : PH_IDLE;
                end
                PH_ADDR:
                begin
                    if (rx_byte == device_address) begin
                        running_crc_next = crc_upd;
                        phase_next       = PH_LEN;
                    end else begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_LEN:
                begin
                    frame_length_next = rx_byte;
                    if (rx_byte > max_length) begin
                        phase_next = PH_IDLE;
                    end else begin
                        running_crc_next = crc_upd;
                        phase_next       = PH_RES;
                    end
                end
                PH_RES:
                begin
                    running_crc_next = crc_upd;
                    phase_next       = PH_DATA;
                end
                PH_DATA:
                begin
                    if (idx == DATA_START)
                        command_next = rx_byte;
                    // With a zero length the single data byte stays out of the CRC.
                    if (idx < frame_end)
                        running_crc_next = crc_upd;
                    if ((idx + 9'd1) >= frame_end) begin
                        computed_crc_next = (idx < frame_end) ? crc_upd : running_crc_reg;
                        phase_next        = PH_CRCH;
                    end
                end
                PH_CRCH:
                begin
                    crc_high_next = rx_byte;
                    phase_next    = PH_CRCL;
                end
                PH_CRCL:
                begin
                    if ((crc_rcvd == computed_crc_reg) || (crc_rcvd == crc_bypass_code))
                        phase_next = PH_TAIL1;
                    else
                        phase_next = PH_IDLE;
                end
                PH_TAIL1:
                begin
                    phase_next = (rx_byte == TAIL1_BYTE) ? PH_TAIL2 : PH_IDLE;
                end
                PH_TAIL2:
                begin
                    phase_next = PH_IDLE;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg        <= PH_IDLE;
            byte_index_reg   <= 9'd0;
            frame_length_reg <= 8'd0;
            running_crc_reg  <= CRC_INIT;
            computed_crc_reg <= 16'd0;
            crc_high_reg     <= 8'd0;
        end else begin
            phase_reg        <= phase_next;
            byte_index_reg   <= byte_index_next;
            frame_length_reg <= frame_length_next;
            running_crc_reg  <= running_crc_next;
            computed_crc_reg <= computed_crc_next;
            crc_high_reg     <= crc_high_next;
        end
    end

    always_ff @(posedge clk)
    begin
        command_reg <= command_next;
    end

endmodule

// File: sv/fpp_reply_tx.sv
// Reply transmitter: serializes the fixed reply frame into the output register,
// one byte per free output slot. Depends on fpp_pkg.
module fpp_reply_tx (
    input  logic                clk,
    input  logic                rst_n,
    input  fpp_pkg::reply_req_t req,
    input  logic [7:0]          device_address,
    input  logic                out_stall,
    output logic                busy,
    output logic                out_valid,
    output logic [7:0]          tx_byte,
    output logic                last
);
    import fpp_pkg::*;

    logic       busy_reg, busy_next;
    logic       is_ctrl_reg, is_ctrl_next;
    logic [3:0] count_reg, count_next;
    logic       out_vld_reg, out_vld_next;
    logic [7:0] tx_byte_reg, tx_byte_next;
    logic       last_reg, last_next;
    logic       slot_free, at_last;

    always_comb
    begin
        slot_free    = !out_vld_reg || !out_stall;
        at_last      = count_reg == (is_ctrl_reg ? LAST_IDX_CTRL : LAST_IDX_READ);
        busy_next    = busy_reg;
        is_ctrl_next = is_ctrl_reg;
        count_next   = count_reg;
        out_vld_next = out_vld_reg;
        tx_byte_next = tx_byte_reg;
        last_next    = last_reg;

        if (slot_free) begin
            out_vld_next = busy_reg;
            if (busy_reg) begin
                tx_byte_next = reply_byte(is_ctrl_reg, count_reg, device_address);
                last_next    = at_last;
                count_next   = count_reg + 4'd1;
                if (at_last)
                    busy_next = 1'b0;
            end
        end

        if (req.valid) begin
            busy_next    = 1'b1;
            is_ctrl_next = req.is_ctrl;
            count_next   = 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg    <= 1'b0;
            is_ctrl_reg <= 1'b0;
            count_reg   <= 4'd0;
            out_vld_reg <= 1'b0;
            tx_byte_reg <= 8'd0;
            last_reg    <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            is_ctrl_reg <= is_ctrl_next;
            count_reg   <= count_next;
            out_vld_reg <= out_vld_next;
            tx_byte_reg <= tx_byte_next;
            last_reg    <= last_next;
        end
    end

    assign busy      = busy_reg;
    assign out_valid = out_vld_reg;
    assign tx_byte   = tx_byte_reg;
    assign last      = last_reg;

endmodule

// File: sv/framed_packet_parser_crc16.sv
// Framed packet parser with CRC-16/Modbus check and fixed reply generator.
// A received byte is parsed from the input register; an accepted tail byte sets
// the transmitter busy, which loads the first reply byte into the output register.
// Per cycle: one byte in unless in_stall, one reply byte out unless out_stall.
// Reset (rst_n, asynchronous, active low) sets the parser to idle, the CRC to
// 0xFFFF and the registers to address 2, max length 100, bypass code 0xAAAA.
module framed_packet_parser_crc16 (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    input  logic        timed_out,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  tx_byte,
    output logic        last,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import fpp_pkg::*;

    // Register indexes of the configuration port.
    localparam logic [1:0] CFG_DEVICE_ADDRESS = 2'd0;
    localparam logic [1:0] CFG_MAX_LENGTH     = 2'd1;
    localparam logic [1:0] CFG_CRC_BYPASS     = 2'd2;

    logic [7:0]  device_address_reg;
    logic [7:0]  max_length_reg;
    logic [15:0] crc_bypass_reg;

    // Input register: holds one request until the parser takes it.
    logic        in_vld_reg, in_vld_next;
    logic [7:0]  in_byte_reg, in_byte_next;
    logic        in_to_reg, in_to_next;

    logic        take;
    logic        tx_busy;
    reply_req_t  req;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            device_address_reg <= ADDR_RESET;
            max_length_reg     <= MAXLEN_RESET;
            crc_bypass_reg     <= BYPASS_RESET;
        end else if (cfg_write) begin
            case (cfg_index)
                CFG_DEVICE_ADDRESS: device_address_reg <= cfg_data[7:0];
                CFG_MAX_LENGTH:     max_length_reg     <= cfg_data[7:0];
                CFG_CRC_BYPASS:     crc_bypass_reg     <= cfg_data;
                default:            ;
            endcase
        end
    end

    // The input side only stalls while a held byte cannot be parsed, which
    // happens when it would start a reply while the previous one is still going.
    assign in_stall = in_vld_reg && !take;

    always_comb
    begin
        in_vld_next  = in_vld_reg;
        in_byte_next = in_byte_reg;
        in_to_next   = in_to_reg;
        if (!in_stall) begin
            in_vld_next  = in_valid;
            in_byte_next = rx_byte;
            in_to_next   = timed_out;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_vld_reg  <= 1'b0;
            in_byte_reg <= 8'd0;
            in_to_reg   <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            in_byte_reg <= in_byte_next;
            in_to_reg   <= in_to_next;
        end
    end

    fpp_parser u_parser (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (in_vld_reg),
        .rx_byte         (in_byte_reg),
        .timed_out       (in_to_reg),
        .device_address  (device_address_reg),
        .max_length      (max_length_reg),
        .crc_bypass_code (crc_bypass_reg),
        .tx_busy         (tx_busy),
        .take            (take),
        .req             (req)
    );

    fpp_reply_tx u_reply_tx (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req),
        .device_address (device_address_reg),
        .out_stall      (out_stall),
        .busy           (tx_busy),
        .out_valid      (out_valid),
        .tx_byte        (tx_byte),
        .last           (last)
    );

    // A reply request never arrives while a reply is still being sent.
    assert property (@(posedge clk) disable iff (!rst_n) req.valid |-> !tx_busy)
        else $error("reply request while transmitter busy");

    // The final reply byte is always the closing tail byte.
    assert property (@(posedge clk) disable iff (!rst_n) (out_valid && last) |-> tx_byte == TAIL2_BYTE)
        else $error("last flag on a byte other than the tail");

    // A reply request leads to a busy transmitter in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) req.valid |=> tx_busy)
        else $error("reply request was dropped");

    // Stall is only raised while the parser blocks on a busy transmitter.
    assert property (@(posedge clk) disable iff (!rst_n) in_stall |-> (in_vld_reg && tx_busy))
        else $error("input stalled without cause");

endmodule
